/* rtl/core/brle_pkg.sv */
// Shared types and constants for the bit vector run length extractor.
package brle_pkg;

    localparam int BitsPerByte = 8;
    // Run end positions: a level change before bit 0..7, plus the flush slot.
    localparam int NumPos      = BitsPerByte + 1;
    localparam int PosBits     = 4;
    localparam int ScaleBits   = 8;
    localparam int DurBits     = 24;
    localparam int ProdBits    = 40;

    localparam logic [ScaleBits-1:0] ScaleReset  = 8'd64;
    localparam logic [DurBits-1:0]   DurationMax = 24'hFF_FFFF;

    // Run end markers of the byte in the run register.
    typedef struct packed {
        logic [NumPos-1:0] mask;
        logic [NumPos-1:0] level;
    } slot_ctl_t;

    // Emitter back to scanner: which run end left this cycle.
    typedef struct packed {
        logic               take;
        logic [PosBits-1:0] pos;
    } emit_stat_t;

endpackage

/* rtl/core/brle_scan.sv */
// Byte scanner: finds run ends in one byte, keeps the open run state.
module brle_scan #(
    parameter int RUN_COUNT_BITS = 16
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             in_valid,
    output logic                                             in_ready,
    input  logic [brle_pkg::BitsPerByte-1:0]                 sample_byte,
    input  logic                                             last_byte,
    input  brle_pkg::emit_stat_t                             stat,
    output brle_pkg::slot_ctl_t                              slot,
    output logic [brle_pkg::NumPos-1:0][RUN_COUNT_BITS-1:0]  lengths
);

    logic                          prev_level_reg, prev_level_next;
    logic                          have_prev_reg, have_prev_next;
    logic [RUN_COUNT_BITS-1:0]     run_length_reg, run_length_next;
    logic [brle_pkg::NumPos-1:0]   mask_reg, mask_next;
    logic [brle_pkg::NumPos-1:0]   level_reg;
    logic [brle_pkg::NumPos-1:0][RUN_COUNT_BITS-1:0] len_reg;

    logic [brle_pkg::NumPos-1:0]   bnd;
    logic [brle_pkg::NumPos-1:0]   lvl;
    logic [brle_pkg::NumPos-1:0][RUN_COUNT_BITS-1:0] len;
    logic [RUN_COUNT_BITS-1:0]     carried;
    logic [brle_pkg::NumPos-1:0]   mask_after;
    logic                          accept;

    // Run ends and lengths for the incoming byte, all positions in parallel.
    always_comb
    begin
        logic                      found;
        logic [2:0]                start;
        logic [RUN_COUNT_BITS:0]   sum;
        carried = have_prev_reg ? run_length_reg : '0;
        bnd[0]  = have_prev_reg && (sample_byte[0] != prev_level_reg);
        lvl[0]  = prev_level_reg;
        for (int j = 1; j < brle_pkg::BitsPerByte; j++)
        begin
            bnd[j] = sample_byte[j] != sample_byte[j-1];
        end
        bnd[brle_pkg::BitsPerByte] = last_byte;
        for (int j = 1; j < brle_pkg::NumPos; j++)
        begin
            lvl[j] = sample_byte[j-1];
        end
        for (int j = 0; j < brle_pkg::NumPos; j++)
        begin
            found = 1'b0;
            start = '0;
            for (int k = 0; k < brle_pkg::BitsPerByte; k++)
            begin
                if (k < j && bnd[k])
                begin
                    found = 1'b1;
                    start = 3'(k);
                end
            end
            // no earlier end in this byte: run continues from the carried count
            sum = {1'b0, carried} + (RUN_COUNT_BITS+1)'(j);
            if (found)
                len[j] = RUN_COUNT_BITS'(j) - RUN_COUNT_BITS'(start);
            else if (sum[RUN_COUNT_BITS])
                len[j] = '1;
            else
                len[j] = sum[RUN_COUNT_BITS-1:0];
        end
    end

    always_comb
    begin
        mask_after            = mask_reg;
        mask_after[stat.pos]  = 1'b0;
        in_ready = (mask_reg == '0) || (stat.take && (mask_after == '0));
        accept   = in_valid && in_ready;

        prev_level_next = prev_level_reg;
        have_prev_next  = have_prev_reg;
        run_length_next = run_length_reg;
        mask_next       = stat.take ? mask_after : mask_reg;
        if (accept)
        begin
            mask_next = bnd;
            if (last_byte)
            begin
                prev_level_next = 1'b0;
                have_prev_next  = 1'b0;
                run_length_next = '0;
            end
            else
            begin
                prev_level_next = sample_byte[brle_pkg::BitsPerByte-1];
                have_prev_next  = 1'b1;
                run_length_next = len[brle_pkg::BitsPerByte];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= 1'b0;
            have_prev_reg  <= 1'b0;
            run_length_reg <= '0;
            mask_reg       <= '0;
        end
        else
        begin
            prev_level_reg <= prev_level_next;
            have_prev_reg  <= have_prev_next;
            run_length_reg <= run_length_next;
            mask_reg       <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            level_reg <= lvl;
            len_reg   <= len;
        end
    end

    assign slot.mask  = mask_reg;
    assign slot.level = level_reg;
    assign lengths    = len_reg;

    a_accept_only_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (mask_reg == '0) || (stat.take && $countones(mask_reg) == 1))
        else $error("byte accepted while earlier runs still pending");

    a_flush_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_byte) |=> (!have_prev_reg && run_length_reg == '0))
        else $error("run state not cleared after final byte");

    a_open_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        have_prev_reg |-> (run_length_reg != '0))
        else $error("open run has zero length");

endmodule

/* rtl/core/brle_emit.sv */
// Run emitter: one finished run per cycle while out_ready allows, scaled and saturated, into the output register.
module brle_emit #(
    parameter int RUN_COUNT_BITS = 16
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             cfg_write_en,
    input  logic [brle_pkg::ScaleBits-1:0]                   cfg_write_data,
    input  brle_pkg::slot_ctl_t                              slot,
    input  logic [brle_pkg::NumPos-1:0][RUN_COUNT_BITS-1:0]  lengths,
    output brle_pkg::emit_stat_t                             stat,
    output logic                                             out_valid,
    input  logic                                             out_ready,
    output logic [brle_pkg::DurBits-1:0]                     run_duration,
    output logic                                             run_was_low,
    output logic                                             last_of_item
);

    logic [brle_pkg::ScaleBits-1:0]  scale_reg;
    logic                            valid_reg, valid_next;
    logic [brle_pkg::DurBits-1:0]    dur_reg;
    logic                            low_reg;
    logic                            last_reg;

    logic [brle_pkg::PosBits-1:0]    pos;
    logic [brle_pkg::NumPos-1:0]     remaining;
    logic                            take;
    logic [brle_pkg::ProdBits-1:0]   prod;
    logic [brle_pkg::DurBits-1:0]    dur;

    always_comb
    begin
        // lowest pending run end goes first
        pos = '0;
        for (int j = brle_pkg::NumPos - 1; j >= 0; j--)
        begin
            if (slot.mask[j])
                pos = brle_pkg::PosBits'(j);
        end
        remaining      = slot.mask;
        remaining[pos] = 1'b0;
        take = (slot.mask != '0) && (!valid_reg || out_ready);

        prod = brle_pkg::ProdBits'(lengths[pos]) * brle_pkg::ProdBits'(scale_reg);
        if (prod[brle_pkg::ProdBits-1:brle_pkg::DurBits] != '0)
            dur = brle_pkg::DurationMax;
        else
            dur = prod[brle_pkg::DurBits-1:0];

        if (take)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= brle_pkg::ScaleReset;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                scale_reg <= cfg_write_data;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            dur_reg  <= dur;
            low_reg  <= ~slot.level[pos];
            last_reg <= (remaining == '0);
        end
    end

    assign stat.take    = take;
    assign stat.pos     = pos;
    assign out_valid    = valid_reg;
    assign run_duration = dur_reg;
    assign run_was_low  = low_reg;
    assign last_of_item = last_reg;

    a_take_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> valid_reg)
        else $error("emitted run did not reach the output register");

    a_last_marks_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (take && remaining == '0) |=> last_reg)
        else $error("final run of a byte not marked");

endmodule

/* rtl/core/bit_vector_run_length_extractor.sv */
// Top level of the bit vector run length extractor.
// Takes captured line samples a byte at a time (bit 0 earliest) and reports each
// finished run of equal samples as run_duration = run length x duration_scale
// (saturated at 24 bits) with run_was_low giving its level; last_of_item marks
// the final run a byte produced, and last_byte flushes the open run so the next
// byte starts a new capture. The scanner finds every run end of a byte in the
// cycle it is accepted; the emitter then sends one run per cycle, while out_ready
// allows, through a RUN_COUNT_BITS x 8 multiply into the output register, and
// takes the next byte as a byte's last run leaves. A byte gives at most 9 runs (a
// change at every bit including bit 0, plus the flush); one that closes no run
// leaves in_ready high. The run counter saturates at 2^RUN_COUNT_BITS - 1.
module bit_vector_run_length_extractor #(
    parameter int RUN_COUNT_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_write_en,
    input  logic [7:0]   cfg_write_data,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   sample_byte,
    input  logic         last_byte,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [23:0]  run_duration,
    output logic         run_was_low,
    output logic         last_of_item
);

    brle_pkg::slot_ctl_t   slot;
    brle_pkg::emit_stat_t  stat;
    logic [brle_pkg::NumPos-1:0][RUN_COUNT_BITS-1:0] lengths;

    brle_scan #(
        .RUN_COUNT_BITS (RUN_COUNT_BITS)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample_byte (sample_byte),
        .last_byte   (last_byte),
        .stat        (stat),
        .slot        (slot),
        .lengths     (lengths)
    );

    brle_emit #(
        .RUN_COUNT_BITS (RUN_COUNT_BITS)
    ) u_emit (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .slot           (slot),
        .lengths        (lengths),
        .stat           (stat),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .run_duration   (run_duration),
        .run_was_low    (run_was_low),
        .last_of_item   (last_of_item)
    );

endmodule

/* dv/brle_checker.sv */
// Checker for the bit vector run length extractor: predicts the runs of each byte and compares.
`timescale 1ns / 1ps
module brle_checker #(
    parameter int RUN_COUNT_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [brle_pkg::ScaleBits-1:0] cfg_write_data,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [7:0]                     sample_byte,
    input  logic                           last_byte,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [brle_pkg::DurBits-1:0]   run_duration,
    input  logic                           run_was_low,
    input  logic                           last_of_item,
    output int                             pending,
    output int                             failures
);

    typedef struct packed {
        logic [brle_pkg::DurBits-1:0] duration;
        logic                         was_low;
        logic                         last;
    } run_rec_t;

    localparam longint unsigned RunMax = (64'd1 << RUN_COUNT_BITS) - 64'd1;

    run_rec_t                       run_queue[$];
    logic [brle_pkg::ScaleBits-1:0] scale;
    logic                           line_level;
    logic                           line_seen;
    longint unsigned                run_count;
    int                             fail_count;

    function automatic run_rec_t close_run(input longint unsigned count, input logic level,
                                           input logic [brle_pkg::ScaleBits-1:0] units);
        longint unsigned product;
        run_rec_t        rec;
        product = count * units;
        rec.duration = (product > brle_pkg::DurationMax) ? brle_pkg::DurationMax
                                                         : brle_pkg::DurBits'(product);
        rec.was_low = ~level;
        rec.last = 1'b0;
        return rec;
    endfunction

    // Walks the byte LSB first and queues every run it closes.
    task automatic scan_byte(input logic [7:0] samples, input logic fin);
        run_rec_t runs[brle_pkg::NumPos];
        int       n;
        logic     bit_now;
        n = 0;
        for (int j = 0; j < brle_pkg::BitsPerByte; j++) begin
            bit_now = samples[j];
            if (!line_seen) begin
                line_seen = 1'b1;
                line_level = bit_now;
                run_count = 1;
            end
            else if (bit_now == line_level) begin
                if (run_count < RunMax)
                    run_count++;
            end
            else begin
                runs[n] = close_run(run_count, line_level, scale);
                n++;
                line_level = bit_now;
                run_count = 1;
            end
        end
        if (fin) begin
            if (line_seen) begin
                runs[n] = close_run(run_count, line_level, scale);
                n++;
            end
            line_level = 1'b0;
            line_seen = 1'b0;
            run_count = 0;
        end
        if (n > 0)
            runs[n-1].last = 1'b1;
        for (int k = 0; k < n; k++)
            run_queue = {run_queue, runs[k]};
    endtask

    always @(posedge clk or negedge rst_n) begin
        run_rec_t want;
        if (!rst_n) begin
            run_queue.delete();
            scale = brle_pkg::ScaleReset;
            line_level = 1'b0;
            line_seen = 1'b0;
            run_count = 0;
            fail_count = 0;
        end
        else begin
            // output first: a run leaving now belongs to an earlier byte
            if (out_valid && out_ready) begin
                if (run_queue.size() == 0) begin
                    $error("run transaction with none expected: run_duration %0d run_was_low %0b",
                           run_duration, run_was_low);
                    fail_count++;
                end
                else begin
                    want = run_queue.pop_front();
                    if (run_duration !== want.duration) begin
                        $error("run_duration: expected %0d, actual %0d",
                               want.duration, run_duration);
                        fail_count++;
                    end
                    if (run_was_low !== want.was_low) begin
                        $error("run_was_low: expected %0b, actual %0b",
                               want.was_low, run_was_low);
                        fail_count++;
                    end
                    if (last_of_item !== want.last) begin
                        $error("last_of_item: expected %0b, actual %0b",
                               want.last, last_of_item);
                        fail_count++;
                    end
                end
            end
            if (cfg_write_en)
                scale = cfg_write_data;
            if (in_valid && in_ready)
                scan_byte(sample_byte, last_byte);
        end
        pending <= run_queue.size();
        failures <= fail_count;
    end

endmodule

/* dv/bit_vector_run_length_extractor_test.sv */
// Testbench top for the bit vector run length extractor: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module bit_vector_run_length_extractor_test;

    localparam int RunCountBits = 16;
    // bytes of one level for a long run
    localparam int LongBytes    = 10;
    localparam int SettleCycles = 12;
    localparam int HoldCycles   = 150;

    typedef enum int {ReadyAlways, ReadyCoin, ReadySparse, ReadyCadence} ready_mode_t;

    logic                           clk            = 1'b0;
    logic                           rst_n          = 1'b0;
    logic                           cfg_write_en   = 1'b0;
    logic [brle_pkg::ScaleBits-1:0] cfg_write_data = '0;
    logic                           in_valid       = 1'b0;
    logic [7:0]                     sample_byte    = '0;
    logic                           last_byte      = 1'b0;
    logic                           out_ready      = 1'b0;
    logic                           in_ready;
    logic                           out_valid;
    logic [brle_pkg::DurBits-1:0]   run_duration;
    logic                           run_was_low;
    logic                           last_of_item;
    int                             pending;
    int                             failures;
    int                             burst_left     = 0;
    bit                             pressure_req   = 1'b0;

    always #5 clk = ~clk;

    bit_vector_run_length_extractor #(
        .RUN_COUNT_BITS(RunCountBits)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample_byte   (sample_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .run_duration  (run_duration),
        .run_was_low   (run_was_low),
        .last_of_item  (last_of_item)
    );

    brle_checker #(
        .RUN_COUNT_BITS(RunCountBits)
    ) run_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample_byte   (sample_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .run_duration  (run_duration),
        .run_was_low   (run_was_low),
        .last_of_item  (last_of_item),
        .pending       (pending),
        .failures      (failures)
    );

    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: stretches of different stall patterns, plus one long hold on request.
    initial begin : receiver
        int          left;
        int          hold;
        int          tick;
        bit          hold_done;
        ready_mode_t mode;
        left = 0;
        hold = 0;
        tick = 0;
        hold_done = 1'b0;
        mode = ReadyAlways;
        forever begin
            @(posedge clk);
            tick++;
            if (pressure_req && !hold_done) begin
                hold = HoldCycles;
                hold_done = 1'b1;
            end
            if (hold > 0) begin
                hold--;
                out_ready <= 1'b0;
            end
            else begin
                if (left == 0) begin
                    mode = ready_mode_t'($urandom_range(0, 3));
                    left = $urandom_range(4, 40);
                end
                left--;
                case (mode)
                    ReadyAlways: out_ready <= 1'b1;
                    ReadyCoin:   out_ready <= ($urandom_range(0, 1) == 1);
                    ReadySparse: out_ready <= ($urandom_range(0, 3) == 0);
                    default:     out_ready <= (tick % 3 != 1);
                endcase
            end
        end
    end

    // One byte transaction; bursts of random length separated by random gaps.
    task automatic send_byte(input logic [7:0] samples, input logic fin);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 10);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        sample_byte <= samples;
        last_byte <= fin;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Wait until every run is out; a byte closing no run may still be in flight.
    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_scale(input logic [brle_pkg::ScaleBits-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        logic [7:0] step_mask;
        case ($urandom_range(0, 6))
            0, 1, 2: return 8'($urandom);
            3:       return 8'h00;
            4:       return 8'hFF;
            5: begin
                // at most one level change somewhere in the byte
                step_mask = 8'hFF << $urandom_range(0, 7);
                return ($urandom_range(0, 1) == 1) ? step_mask : ~step_mask;
            end
            default: return ($urandom_range(0, 1) == 1) ? 8'h55 : 8'hAA;
        endcase
    endfunction

    // Captures of a few bytes closed by last_byte; some left open, some cut short.
    task automatic run_captures(input int count);
        int   sent;
        int   len;
        logic fin;
        sent = 0;
        while (sent < count) begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
                fin = (k == len - 1) ? ($urandom_range(0, 7) != 0)
                                     : ($urandom_range(0, 15) == 0);
                send_byte(pick_byte(), fin);
                sent++;
            end
        end
    endtask

    task automatic run_phase(input logic [brle_pkg::ScaleBits-1:0] scale, input int count);
        settle();
        write_scale(scale);
        run_captures(count);
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset scale; first byte only opens a run, alternating bytes close seven
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hF0, 1'b1);
        // fresh capture flushed at once: seven changes plus the flush
        send_byte(8'h55, 1'b1);
        send_byte(8'hAA, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'h3C, 1'b0);
        send_byte(8'hC3, 1'b1);
        // change at bit 0 as well: nine runs from one byte
        send_byte(8'h00, 1'b0);
        send_byte(8'h55, 1'b1);

        run_phase(8'd1, 40);
        // zero scale is accepted and gives zero durations
        run_phase(8'd0, 30);

        // long runs, low run closed by a change, high run by the flush
        settle();
        write_scale(8'd255);
        repeat (LongBytes) send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        repeat (LongBytes) send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);

        // long receiver hold while bytes keep coming
        settle();
        write_scale(8'd255);
        pressure_req = 1'b1;
        run_captures(40);

        run_phase(8'($urandom_range(2, 254)), 40);
        run_phase(8'($urandom_range(1, 255)), 40);
        settle();

        if (failures == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
